@@ rtl/pbssa_pkg.sv @@
// Shared constants and types for the per-bin sum and square accumulator.
package pbssa_pkg;

    localparam int MAX_BINS  = 1024;
    localparam int MAX_SHOTS = 65536;

    localparam int SAMPLE_W  = 16;
    localparam int SHIFT     = 2;
    localparam int VAL_W     = SAMPLE_W - SHIFT;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int SHOT_W    = $clog2(MAX_SHOTS);
    localparam int BINS_W    = BIN_W + 1;
    localparam int SHOTS_W   = SHOT_W + 1;
    localparam int SUM_W     = 30;
    localparam int SQ_W      = 43;
    localparam int ENTRY_W   = SUM_W + SQ_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = SHOTS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BINS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOTS = 1'b1;

    typedef logic [BIN_W-1:0]   t_bin;
    typedef logic [SHOT_W-1:0]  t_shot;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [SQ_W-1:0]    t_sq;
    typedef logic [ENTRY_W-1:0] t_entry;

endpackage

@@ rtl/pbssa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module pbssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/per_bin_sum_and_square_accumulator.sv @@
// Top level of the per-bin sum and sum-of-squares accumulator.
//
// Signed 16-bit samples arrive shot by shot; each is shifted right by two and its value and
// square are accumulated into the bin given by its position in the shot, the first shot
// overwriting the bin. The block accepts one item per cycle while the output is taken.
// An accepted item passes through the read stage and then the result register before
// its result is valid. The per-bin totals live in one 1024-entry RAM that is read and
// then written for each item, and a forwarding register covers back-to-back items that
// hit the same bin. Input is held off only while a result waits at the output. The bin
// store is not cleared at reset, since the first shot writes every bin before it is read.
module per_bin_sum_and_square_accumulator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pbssa_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pbssa_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [pbssa_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [pbssa_pkg::BIN_W-1:0]            o_bin_index,
    output logic signed [pbssa_pkg::SUM_W-1:0]     o_bin_sum,
    output logic [pbssa_pkg::SQ_W-1:0]             o_bin_sum_sq,
    output logic                                   o_final_res
);

    localparam int BINS_W  = pbssa_pkg::BINS_W;
    localparam int SHOTS_W = pbssa_pkg::SHOTS_W;
    localparam int VAL_W   = pbssa_pkg::VAL_W;
    localparam int PROD_W  = pbssa_pkg::PROD_W;
    localparam int SUM_W   = pbssa_pkg::SUM_W;
    localparam int SQ_W    = pbssa_pkg::SQ_W;

    localparam logic [BINS_W-1:0]  MaxBins  = BINS_W'(pbssa_pkg::MAX_BINS);
    localparam logic [SHOTS_W-1:0] MaxShots = SHOTS_W'(pbssa_pkg::MAX_SHOTS);

    logic [BINS_W-1:0]  r_cfg_bins;
    logic [SHOTS_W-1:0] r_cfg_shots;
    pbssa_pkg::t_bin    r_bin_cnt;
    pbssa_pkg::t_shot   r_shot_cnt;

    logic                        r_p1_valid;
    pbssa_pkg::t_bin             r_p1_bin;
    logic signed [VAL_W-1:0]     r_p1_val;
    logic [PROD_W-1:0]           r_p1_sq;
    logic                        r_p1_first;
    logic                        r_p1_final;

    logic           r_fwd;
    pbssa_pkg::t_sum r_fwd_sum;
    pbssa_pkg::t_sq  r_fwd_sq;

    logic            r_out_valid;
    pbssa_pkg::t_bin r_out_bin;
    pbssa_pkg::t_sum r_out_sum;
    pbssa_pkg::t_sq  r_out_sq;
    logic            r_out_final;

    logic [BINS_W-1:0]       bins_eff;
    logic [SHOTS_W-1:0]      shots_eff;
    logic                    out_free;
    logic                    p1_move;
    logic                    in_ready;
    logic                    accept;
    logic                    final_shot;
    logic                    shot_wrap;
    logic signed [VAL_W-1:0] val;
    logic signed [PROD_W-1:0] prod;
    pbssa_pkg::t_bin         raddr;
    pbssa_pkg::t_entry       rdata;
    pbssa_pkg::t_sum         base_sum;
    pbssa_pkg::t_sq          base_sq;
    pbssa_pkg::t_sum         val_ext;
    pbssa_pkg::t_sq          sq_ext;
    pbssa_pkg::t_sum         n_sum;
    pbssa_pkg::t_sq          n_sq;

    always_comb begin
        if (r_cfg_bins == '0) begin
            bins_eff = BINS_W'(1);
        end else if (r_cfg_bins > MaxBins) begin
            bins_eff = MaxBins;
        end else begin
            bins_eff = r_cfg_bins;
        end
        if (r_cfg_shots == '0) begin
            shots_eff = SHOTS_W'(1);
        end else if (r_cfg_shots > MaxShots) begin
            shots_eff = MaxShots;
        end else begin
            shots_eff = r_cfg_shots;
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign p1_move    = r_p1_valid && out_free;
    assign in_ready   = !r_p1_valid || p1_move;
    assign accept     = i_in_valid && in_ready;
    assign o_in_ready = in_ready;

    assign final_shot = ({1'b0, r_shot_cnt} + SHOTS_W'(1)) >= shots_eff;
    assign shot_wrap  = ({1'b0, r_bin_cnt} + BINS_W'(1)) >= bins_eff;
    assign val        = i_sample[pbssa_pkg::SAMPLE_W-1:pbssa_pkg::SHIFT];
    assign prod       = val * val;
    assign raddr      = accept ? r_bin_cnt : r_p1_bin;

    pbssa_ram #(
        .WIDTH(pbssa_pkg::ENTRY_W),
        .DEPTH(pbssa_pkg::MAX_BINS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (p1_move),
        .i_waddr(r_p1_bin),
        .i_wdata({n_sum, n_sq}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        base_sum = r_fwd ? r_fwd_sum : rdata[pbssa_pkg::ENTRY_W-1:SQ_W];
        base_sq  = r_fwd ? r_fwd_sq  : rdata[SQ_W-1:0];
        val_ext  = SUM_W'(r_p1_val);
        sq_ext   = {{(SQ_W-PROD_W){1'b0}}, r_p1_sq};
        if (r_p1_first) begin
            n_sum = val_ext;
            n_sq  = sq_ext;
        end else begin
            n_sum = base_sum + val_ext;
            n_sq  = base_sq + sq_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bins  <= MaxBins;
            r_cfg_shots <= MaxShots;
            r_bin_cnt   <= '0;
            r_shot_cnt  <= '0;
            r_p1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pbssa_pkg::CFG_BINS: begin
                        r_cfg_bins <= i_cfg_data[BINS_W-1:0];
                    end
                    pbssa_pkg::CFG_SHOTS: begin
                        r_cfg_shots <= i_cfg_data;
                    end
                    default: begin
                        r_cfg_bins <= r_cfg_bins;
                    end
                endcase
            end
            if (accept) begin
                if (shot_wrap) begin
                    r_bin_cnt  <= '0;
                    r_shot_cnt <= final_shot ? '0 : r_shot_cnt + 1'b1;
                end else begin
                    r_bin_cnt <= r_bin_cnt + 1'b1;
                end
                r_fwd <= p1_move && (r_p1_bin == r_bin_cnt);
            end else if (p1_move) begin
                r_fwd <= 1'b0;
            end
            if (accept) begin
                r_p1_valid <= 1'b1;
            end else if (p1_move) begin
                r_p1_valid <= 1'b0;
            end
            if (p1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_bin   <= r_bin_cnt;
            r_p1_val   <= val;
            r_p1_sq    <= prod;
            r_p1_first <= (r_shot_cnt == '0);
            r_p1_final <= final_shot;
            r_fwd_sum  <= n_sum;
            r_fwd_sq   <= n_sq;
        end
        if (p1_move) begin
            r_out_bin   <= r_p1_bin;
            r_out_sum   <= n_sum;
            r_out_sq    <= n_sq;
            r_out_final <= r_p1_final;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bin_index  = r_out_bin;
    assign o_bin_sum    = r_out_sum;
    assign o_bin_sum_sq = r_out_sq;
    assign o_final_res  = r_out_final;

    a_move_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p1_move |=> (o_out_valid && o_bin_index == $past(r_p1_bin)))
        else $error("result register did not take the item leaving the read stage");

    a_first_shot_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (p1_move && r_p1_first) |=> (o_bin_sum == SUM_W'($past(r_p1_val))))
        else $error("first shot did not overwrite the bin sum");

    a_read_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && !out_free) |=> (r_p1_valid && $stable(r_p1_bin)))
        else $error("read stage lost its item while the output was stalled");

    a_fwd_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_p1_valid)
        else $error("forwarding set without an item in the read stage");

endmodule

@@ verif/tb_per_bin_sum_and_square_accumulator.sv @@
// Self-checking testbench for the per-bin sum and sum-of-squares accumulator.
`timescale 1ns / 100ps

module tb_per_bin_sum_and_square_accumulator;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HIGH_W = pbssa_pkg::CFG_W - pbssa_pkg::BINS_W;

    typedef logic [pbssa_pkg::CFG_W-1:0]    t_cfg;
    typedef logic [pbssa_pkg::SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        pbssa_pkg::t_bin bin;
        pbssa_pkg::t_sum sum;
        pbssa_pkg::t_sq  sq;
        logic            fin;
    } t_bin_totals;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic [pbssa_pkg::CFG_IDX_W-1:0]  idx;
        t_cfg                             data;
        t_sample                          sample;
        logic                             typed;
        t_bin_totals                      want;
    } t_stim_row;

    localparam t_bin_totals NO_TOTALS = '0;

    localparam t_stim_row DIRECTED_ROWS [28] = '{
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h0000, 1'b1,
          '{10'd0, 30'sd0, 43'd0, 1'b0}},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h7FFF, 1'b1,
          '{10'd1, 30'sd8191, 43'd67092481, 1'b0}},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h8000, 1'b1,
          '{10'd2, -30'sd8192, 43'd67108864, 1'b0}},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'hFFFF, 1'b1,
          '{10'd3, -30'sd1, 43'd1, 1'b0}},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h0003, 1'b1,
          '{10'd4, 30'sd0, 43'd0, 1'b0}},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'hFFFC, 1'b1,
          '{10'd5, -30'sd1, 43'd1, 1'b0}},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h0004, 1'b1,
          '{10'd6, 30'sd1, 43'd1, 1'b0}},
        '{ROW_CFG, pbssa_pkg::CFG_SHOTS, 17'd0, 16'h0000, 1'b0, NO_TOTALS},
        '{ROW_CFG, pbssa_pkg::CFG_BINS, 17'd0, 16'h0000, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h1234, 1'b1,
          '{10'd7, 30'sd1165, 43'd1357225, 1'b1}},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h8000, 1'b1,
          '{10'd0, -30'sd8192, 43'd67108864, 1'b1}},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h7FFF, 1'b1,
          '{10'd0, 30'sd8191, 43'd67092481, 1'b1}},
        '{ROW_CFG, pbssa_pkg::CFG_BINS, 17'd2047, 16'h0000, 1'b0, NO_TOTALS},
        '{ROW_CFG, pbssa_pkg::CFG_SHOTS, 17'h1FFFF, 16'h0000, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h5555, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'hAAAA, 1'b0, NO_TOTALS},
        '{ROW_CFG, pbssa_pkg::CFG_BINS, 17'd3, 16'h0000, 1'b0, NO_TOTALS},
        '{ROW_CFG, pbssa_pkg::CFG_SHOTS, 17'd3, 16'h0000, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h7FFF, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h7FFF, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h8000, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'hFFFF, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h0100, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'hFEFF, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h7FFF, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h8000, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h1234, 1'b0, NO_TOTALS},
        '{ROW_SAMPLE, pbssa_pkg::CFG_BINS, 17'd0, 16'h0FFC, 1'b0, NO_TOTALS}
    };

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_cfg_we = 1'b0;
    logic [pbssa_pkg::CFG_IDX_W-1:0]       i_cfg_idx = pbssa_pkg::CFG_BINS;
    t_cfg                                  i_cfg_data = '0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_ready;
    logic signed [pbssa_pkg::SAMPLE_W-1:0] i_sample = '0;
    logic                                  o_out_valid;
    logic                                  i_out_ready = 1'b0;
    pbssa_pkg::t_bin                       o_bin_index;
    logic signed [pbssa_pkg::SUM_W-1:0]    o_bin_sum;
    pbssa_pkg::t_sq                        o_bin_sum_sq;
    logic                                  o_final_res;

    int          send_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    t_bin_totals expected_totals [$];

    int              bins_reg = pbssa_pkg::MAX_BINS;
    int              shots_reg = pbssa_pkg::MAX_SHOTS;
    int              bin_cnt = 0;
    int              shot_cnt = 0;
    pbssa_pkg::t_sum sum_mem [pbssa_pkg::MAX_BINS];
    pbssa_pkg::t_sq  sq_mem [pbssa_pkg::MAX_BINS];
    bit              bin_written [pbssa_pkg::MAX_BINS];

    per_bin_sum_and_square_accumulator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_bin_index  (o_bin_index),
        .o_bin_sum    (o_bin_sum),
        .o_bin_sum_sq (o_bin_sum_sq),
        .o_final_res  (o_final_res)
    );

    always #5 i_clk = ~i_clk;

    function automatic int eff_count(input int v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void accumulate_sample(input t_sample s, output t_bin_totals r);
        int                                    nb;
        int                                    ns;
        int                                    bin;
        logic signed [pbssa_pkg::SAMPLE_W-1:0] sx;
        longint                                v;
        bit                                    fin;
        nb = eff_count(bins_reg, pbssa_pkg::MAX_BINS);
        ns = eff_count(shots_reg, pbssa_pkg::MAX_SHOTS);
        sx = s;
        v = sx >>> pbssa_pkg::SHIFT;
        bin = bin_cnt % pbssa_pkg::MAX_BINS;
        fin = (shot_cnt + 1) >= ns;
        if (shot_cnt == 0) begin
            sum_mem[bin] = pbssa_pkg::t_sum'(v);
            sq_mem[bin] = pbssa_pkg::t_sq'(v * v);
            bin_written[bin] = 1'b1;
        end else begin
            sum_mem[bin] = sum_mem[bin] + pbssa_pkg::t_sum'(v);
            sq_mem[bin] = sq_mem[bin] + pbssa_pkg::t_sq'(v * v);
        end
        r.bin = pbssa_pkg::t_bin'(bin);
        r.sum = sum_mem[bin];
        r.sq = sq_mem[bin];
        r.fin = fin;
        if (bin_cnt + 1 >= nb) begin
            bin_cnt = 0;
            shot_cnt = fin ? 0 : shot_cnt + 1;
        end else begin
            bin_cnt = bin_cnt + 1;
        end
    endfunction

    // A bin count may only grow past bins that the first shot has written.
    function automatic bit bins_change_safe(input int raw);
        int nb;
        int lim;
        nb = eff_count(raw, pbssa_pkg::MAX_BINS);
        lim = (nb > bin_cnt + 1) ? nb : bin_cnt + 1;
        if (shot_cnt == 0) return 1'b1;
        for (int i = 0; i < lim; i++) begin
            if (!bin_written[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_cfg pick_bins_data();
        int   r;
        t_cfg d;
        r = $urandom_range(99);
        if (r < 5) d = '0;
        else if (r < 10) d = t_cfg'(1);
        else if (r < 15) d = t_cfg'(pbssa_pkg::MAX_BINS);
        else if (r < 18) d = t_cfg'(2047);
        else if (r < 22) d = t_cfg'($urandom_range(17, 2047));
        else d = t_cfg'($urandom_range(2, 12));
        d[pbssa_pkg::CFG_W-1:pbssa_pkg::BINS_W] = HIGH_W'($urandom);
        return d;
    endfunction

    function automatic t_cfg pick_shots_data();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return t_cfg'(1);
        if (r < 13) return t_cfg'(pbssa_pkg::MAX_SHOTS);
        if (r < 15) return 17'h1FFFF;
        if (r < 18) return t_cfg'($urandom_range(7, 131071));
        return t_cfg'($urandom_range(2, 6));
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(19))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return t_sample'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_sample(input t_sample s, input bit typed, input t_bin_totals want);
        t_bin_totals pred;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_in_ready);
        accumulate_sample(s, pred);
        expected_totals.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_totals.size() != 0);
    endtask

    task automatic write_regs(input bit do_bins, input t_cfg bins_data,
                              input bit do_shots, input t_cfg shots_data);
        drain_results();
        repeat (4) @(posedge i_clk);
        if (do_bins) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= pbssa_pkg::CFG_BINS;
            i_cfg_data <= bins_data;
            @(posedge i_clk);
            bins_reg = int'(bins_data[pbssa_pkg::BINS_W-1:0]);
        end
        if (do_shots) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= pbssa_pkg::CFG_SHOTS;
            i_cfg_data <= shots_data;
            @(posedge i_clk);
            shots_reg = int'(shots_data[pbssa_pkg::SHOTS_W-1:0]);
        end
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_bin_totals got;
        t_bin_totals want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_bin_index, o_bin_sum, o_bin_sum_sq, o_final_res};
            if (expected_totals.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected item: bin %0d sum %0d sq %0d final %0b",
                             got.bin, $signed(got.sum), got.sq, got.fin);
                mismatch_count++;
            end else begin
                want = expected_totals.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 want.bin, $signed(want.sum), want.sq, want.fin,
                                 got.bin, $signed(got.sum), got.sq, got.fin);
                    mismatch_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int   total_random;
        int   items;
        int   tries;
        bit   do_b;
        bit   do_s;
        t_cfg bd;
        t_cfg sd;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        rcv_idle_pct = 66;
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG)
                write_regs(DIRECTED_ROWS[i].idx == pbssa_pkg::CFG_BINS,
                           DIRECTED_ROWS[i].data,
                           DIRECTED_ROWS[i].idx == pbssa_pkg::CFG_SHOTS,
                           DIRECTED_ROWS[i].data);
            else
                send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].typed,
                            DIRECTED_ROWS[i].want);
        end

        total_random = 0;
        while (total_random < RANDOM_ITEMS) begin
            if (total_random < RANDOM_ITEMS / 3) begin
                send_idle_pct = 9;
                rcv_idle_pct = 66;
            end else if (total_random < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 66;
                rcv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            do_b = ($urandom_range(99) < 70);
            do_s = ($urandom_range(99) < 70) || !do_b;
            tries = 0;
            do begin
                bd = pick_bins_data();
                tries++;
            end while (!bins_change_safe(int'(bd[pbssa_pkg::BINS_W-1:0])) && tries < 20);
            if (!bins_change_safe(int'(bd[pbssa_pkg::BINS_W-1:0]))) do_b = 1'b0;
            sd = pick_shots_data();
            write_regs(do_b, bd, do_s, sd);
            items = $urandom_range(8, 40);
            for (int k = 0; k < items; k++) begin
                send_sample(pick_sample(), 1'b0, NO_TOTALS);
                if ($urandom_range(199) == 0) drain_results();
            end
            total_random += items;
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_totals.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
